### rtl/core/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg: shared types and constants of the LRU key/value cache
// Entry and cell control structs, sizes and the controller state type.
// ----------------------------------------------------------------------------
package lkv_pkg;

  // Number of cells in the chain.
  localparam int ENTRIES = 16;

  // Field widths.
  localparam int KEY_W = 32;
  localparam int DATA_W = 32;
  localparam int CAP_W = 5;

  // Cell position and fill count widths follow from the depth.
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes of the func field.
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  // One stored entry as it moves from cell to cell.
  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
  } lkv_entry_t;

  // Control that the controller broadcasts to every cell.
  typedef struct packed {
    logic             lookup;
    logic             update;
    logic             hit;
    logic             set_miss;
    logic [IDX_W-1:0] miss_pos;
  } lkv_cell_ctl_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkv_state_t;

endpackage

### rtl/core/lkv_in_if.sv
// ----------------------------------------------------------------------------
// lkv_in_if: request channel of the LRU key/value cache
// Carries one get or set request word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lkv_in_if;
  import lkv_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink (input valid, input func, input key, input value, output ready);

endinterface

### rtl/core/lkv_out_if.sv
// ----------------------------------------------------------------------------
// lkv_out_if: result channel of the LRU key/value cache
// Carries one result word (found flag and read value) with valid/ready.
// ----------------------------------------------------------------------------
interface lkv_out_if;
  import lkv_pkg::*;

  logic              valid;
  logic              ready;
  logic              found;
  logic [DATA_W-1:0] read_value;

  modport source (output valid, output found, output read_value, input ready);
  modport sink (input valid, input found, input read_value, output ready);

endinterface

### rtl/core/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache with LRU replacement
// Top level: request capture, lookup/update controller, chain of cells and
// result register.
// ----------------------------------------------------------------------------
// The cache keeps its entries in a chain of cells ordered by recency, the
// most recent in cell 0. Each request has a lookup cycle in which every cell
// compares its key, then an update cycle in which the cells up to the hit (or
// the chosen slot on a set miss) shift one place and the request's entry
// enters cell 0; a get miss leaves the chain as it is. A new request is taken
// while idle or in the update cycle of the previous one, once the result
// register is free; the result register lets the next lookup run while a
// result waits to be taken. A set miss fills a free cell while fewer entries
// are held than the capacity register allows (0 acts as 1, above the depth as
// the depth) and otherwise evicts the least recent entry. A get miss returns
// found = 0 and a read value of 0. Valid bits and the fill count clear at reset.
module lru_key_value_cache import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  lkv_in_if.sink           in_ch,
  lkv_out_if.source        out_ch
);

  lkv_state_t        state_r;
  lkv_state_t        state_nxt;
  logic              func_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] value_r;
  logic              hit_r;
  logic [DATA_W-1:0] hit_data_r;
  logic [DATA_W-1:0] hit_data;
  logic              can_fill_r;
  logic [IDX_W-1:0]  miss_pos_r;
  logic [CNT_W-1:0]  fill_r;
  logic [CAP_W-1:0]  cap_r;
  logic [CNT_W-1:0]  cap_eff;
  logic              can_fill;
  logic [IDX_W-1:0]  miss_pos;
  logic              out_valid_r;
  logic              out_found_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic              out_free;
  logic              in_fire;
  logic              do_update;
  lkv_cell_ctl_t     cell_ctl;
  lkv_entry_t        new_entry;
  lkv_entry_t        cell_entry [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  logic [ENTRIES:0]   take_chain;

  // Handshakes.
  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) || ((state_r == ST_UPDATE) && out_free);
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign do_update  = (state_r == ST_UPDATE) && out_free;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // Effective capacity: zero acts as one, large values saturate at the depth.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(ENTRIES)) begin
      cap_eff = CNT_W'(ENTRIES);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  // A set miss fills the next free cell or replaces the last (least recent) one.
  assign can_fill = fill_r < cap_eff;
  assign miss_pos = can_fill ? IDX_W'(fill_r) : IDX_W'(fill_r - CNT_W'(1));

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_ch.func;
      key_r   <= in_ch.key;
      value_r <= in_ch.value;
    end
  end

  // Controller state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = in_fire ? ST_LOOKUP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Data of the hit cell; at most one cell matches.
  always_comb begin
    hit_data = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_vec[i]) begin
        hit_data = hit_data | cell_entry[i].data;
      end
    end
  end

  // Lookup results held for the update cycle.
  always_ff @(posedge clk) begin
    if (state_r == ST_LOOKUP) begin
      hit_r      <= |match_vec;
      hit_data_r <= hit_data;
      can_fill_r <= can_fill;
      miss_pos_r <= miss_pos;
    end
  end

  // Fill count grows on every set miss that takes a free cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (do_update && (func_r == FUNC_SET) && !hit_r && can_fill_r) begin
      fill_r <= fill_r + CNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_update) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      out_found_r      <= hit_r;
      out_read_value_r <= (hit_r && (func_r == FUNC_GET)) ? hit_data_r : '0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = out_found_r;
  assign out_ch.read_value = out_read_value_r;

  // Control broadcast to the cells; a get miss leaves the chain untouched.
  assign cell_ctl = '{
    lookup:   (state_r == ST_LOOKUP),
    update:   do_update,
    hit:      hit_r,
    set_miss: (func_r == FUNC_SET) && !hit_r,
    miss_pos: miss_pos_r
  };

  // On a hit or a set, the request's entry becomes the most recent one.
  assign new_entry = '{
    valid: 1'b1,
    key:   key_r,
    data:  (func_r == FUNC_SET) ? value_r : hit_data_r
  };

  // Chain of cells, cell 0 most recent.
  assign take_chain[ENTRIES] = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkv_entry_t entry_src;

    if (g == 0) begin : g_head
      assign entry_src = new_entry;
    end else begin : g_body
      assign entry_src = cell_entry[g-1];
    end

    lkv_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cell_idx   (IDX_W'(g)),
      .ctl        (cell_ctl),
      .search_key (key_r),
      .entry_in   (entry_src),
      .take_in    (take_chain[g+1]),
      .take_out   (take_chain[g]),
      .match      (match_vec[g]),
      .entry_out  (cell_entry[g])
    );

    assign valid_vec[g] = cell_entry[g].valid;
  end

  // Keys are unique, so a lookup never matches more than one cell.
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOKUP) |-> $onehot0(match_vec))
    else $error("more than one cell matches the search key");

  // Valid cells always equal the fill count.
  a_fill_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(fill_r))
    else $error("fill count disagrees with valid cells");

  // The fill count never exceeds the depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(ENTRIES))
    else $error("fill count above depth");

  // An accepted request is looked up in the next cycle.
  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOKUP))
    else $error("accepted request not looked up");

  // Every update produces a result word.
  a_update_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    do_update |=> out_valid_r)
    else $error("update without result");

endmodule

### rtl/core/lkv_cell.sv
// ----------------------------------------------------------------------------
// lkv_cell: one storage cell of the recency-ordered chain
// Holds one entry, compares it against the search key and, on update, takes
// the entry of its more recent neighbor when the shift window covers it.
// ----------------------------------------------------------------------------
module lkv_cell import lkv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  lkv_cell_ctl_t    ctl,
  input  logic [KEY_W-1:0] search_key,
  input  lkv_entry_t       entry_in,
  input  logic             take_in,
  output logic             take_out,
  output logic             match,
  output lkv_entry_t       entry_out
);

  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic              match_r;
  logic              sel;

  // Associative compare against the search key.
  assign match = valid_r && (key_r == search_key);

  // This cell is the end of the shift window: the hit cell, or the slot
  // chosen for a set miss.
  assign sel = ctl.hit ? match_r : (ctl.set_miss && (cell_idx == ctl.miss_pos));

  // The window covers every cell at or before its end.
  assign take_out = sel || take_in;

  assign entry_out = '{valid: valid_r, key: key_r, data: data_r};

  // Match flag held from the lookup cycle to the update cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.lookup) begin
      match_r <= match;
    end
  end

  // Valid bit shifts along with the entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.update && take_out) begin
      valid_r <= entry_in.valid;
    end
  end

  // Key and data need no reset.
  always_ff @(posedge clk) begin
    if (ctl.update && take_out) begin
      key_r  <= entry_in.key;
      data_r <= entry_in.data;
    end
  end

endmodule
